// File: hw/rtl/motor_speed_pid_loop_assert.svh
// assertion macros for the motor speed pid loop
// relies on clk and rst_n being in scope where the macros are used
`ifndef MOTOR_SPEED_PID_LOOP_ASSERT_SVH
`define MOTOR_SPEED_PID_LOOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MSPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mspl assertion failed");

// antecedent implies consequent in the following cycle
`define MSPL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mspl assertion failed");

`endif

// File: hw/rtl/mspl_pkg.sv
// shared types and constants for the motor speed pid loop
// no dependencies
`default_nettype none

package mspl_pkg;

  localparam int NUM_MOTORS = 2;
  localparam int CH_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  // serial multiplier: signed multiplicand, unsigned multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial divider: unsigned dividend and divisor
  localparam int DIV_N_W = 33;
  localparam int DIV_D_W = 13;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int U_W = 61;

  localparam logic [39:0] SPEED_LIM = 40'd1073741824;
  localparam logic [42:0] INTEG_LIM = 43'd54007488;
  localparam logic [U_W-1:0] SAT_MAG = U_W'(64'd7340032000);
  localparam logic [DIV_D_W-1:0] RPM_FULL = 13'd6800;
  localparam logic [16:0] PWM_FULL = 17'd65535;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ERR,
    ST_MUL_INT,
    ST_DIV_DER,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SCALE,
    ST_DIV_OUT,
    ST_OUT
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

`default_nettype wire

// File: hw/rtl/mspl_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mspl_pkg
`default_nettype none

module mspl_mul (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire logic signed [mspl_pkg::MUL_A_W-1:0]    a,
  input  wire logic        [mspl_pkg::MUL_B_W-1:0]    b,
  output mspl_pkg::unit_st_t                          st,
  output logic signed      [mspl_pkg::MUL_P_W-1:0]    prod
);
  import mspl_pkg::*;

  logic signed [MUL_A_W:0]   a_r;
  logic signed [MUL_A_W:0]   hi_r;
  logic        [MUL_B_W-1:0] lo_r;
  logic [MUL_CNT_W-1:0]      cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic signed [MUL_A_W:0]   sum;

  // partial product add on the upper half
  assign sum = hi_r + (lo_r[0] ? a_r : '0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift right arithmetically after each add
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= {a[MUL_A_W-1], a};
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= {sum[MUL_A_W], sum[MUL_A_W:1]};
      lo_r <= {sum[0], lo_r[MUL_B_W-1:1]};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign prod    = {hi_r, lo_r};

endmodule

`default_nettype wire

// File: hw/rtl/mspl_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on mspl_pkg
`default_nettype none

module mspl_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mspl_pkg::DIV_N_W-1:0]  num,
  input  wire logic [mspl_pkg::DIV_D_W-1:0]  den,
  output mspl_pkg::unit_st_t                 st,
  output logic      [mspl_pkg::DIV_N_W-1:0]  quo
);
  import mspl_pkg::*;

  logic [DIV_D_W:0]   rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_r[DIV_D_W-1:0], quo_r[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      quo_r <= {quo_r[DIV_N_W-2:0], fits};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quo     = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/motor_speed_pid_loop.sv
// motor speed pid loop: one drive command per encoder sample on a shared serial datapath.
// each sample runs four serial multiplies and two serial divides, one after another; the output
// divide is skipped when the command saturates. a new input beat is taken only in idle, after
// the last result has entered the output register; a finished result waits there while the
// next sample runs.
// synchronous active-low reset restores register defaults and clears per-motor state.
`default_nettype none

`include "motor_speed_pid_loop_assert.svh"

module motor_speed_pid_loop (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] encoder_count
  input  wire logic [0:0]  in_tuser,   // [0] motor_select
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [16:0] drive_value, [23:17] zero
  output logic [1:0]       out_tuser,  // [0] motor_id, [1] drive_saturated
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import mspl_pkg::*;

  // configuration registers
  logic signed [13:0] target_r;
  logic [23:0]        gain_p_r;
  logic [23:0]        gain_i_r;
  logic [23:0]        gain_d_r;
  logic [9:0]         period_r;

  // per-motor state
  logic signed [31:0] last_count_r [NUM_MOTORS];
  logic signed [27:0] integ_acc_r  [NUM_MOTORS];
  logic signed [31:0] last_err_r   [NUM_MOTORS];
  logic               dir_r        [NUM_MOTORS];

  // working registers
  state_t             state_r, state_nxt;
  logic [CH_W-1:0]    ch_r;
  logic signed [31:0] count_r;
  logic signed [31:0] speed_r;
  logic signed [31:0] err_r;
  logic signed [27:0] integ_base_r;
  logic signed [27:0] integ_r;
  logic               dneg_r;
  logic signed [MUL_A_W-1:0] deriv_r;
  logic signed [U_W-1:0] u_r;
  logic               uneg_r;
  logic [16:0]        q_r;
  logic               sat_r;

  logic               out_valid_r;
  logic               out_id_r;
  logic [16:0]        out_drive_r;
  logic               out_sat_r;

  // arithmetic unit hookup
  logic                      mul_start, div_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  unit_st_t                  mul_st, div_st;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic [DIV_N_W-1:0]        div_num;
  logic [DIV_D_W-1:0]        div_den;
  logic [DIV_N_W-1:0]        div_quo;

  mspl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .st    (mul_st),
    .prod  (mul_prod)
  );

  mspl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .st    (div_st),
    .quo   (div_quo)
  );

  // datapath combinational values
  logic [9:0]         per_eff;
  logic signed [32:0] cdiff;
  logic signed [39:0] d40, spd75;
  logic signed [31:0] speed_c;
  logic signed [31:0] err_c;
  logic               tpos, tneg;
  logic signed [42:0] isum;
  logic signed [27:0] integ_c;
  logic signed [32:0] ediff;
  logic [DIV_N_W-1:0] emag;
  logic [U_W-1:0]     umag;
  logic [48:0]        scaled;
  logic signed [MUL_A_W-1:0] dq;

  assign per_eff = (period_r == 10'd0) ? 10'd1 : period_r;

  // speed in q.4: count change times 75, saturated
  assign cdiff = {count_r[31], count_r} - {last_count_r[ch_r][31], last_count_r[ch_r]};
  assign d40   = 40'(cdiff);
  assign spd75 = (d40 <<< 6) + (d40 <<< 3) + (d40 <<< 1) + d40;
  always_comb begin
    if (spd75 > $signed(SPEED_LIM)) begin
      speed_c = 32'sd1073741824;
    end else if (spd75 < -$signed(SPEED_LIM)) begin
      speed_c = -32'sd1073741824;
    end else begin
      speed_c = spd75[31:0];
    end
  end

  // error in q.4
  assign tpos  = !target_r[13] && (target_r != 14'sd0);
  assign tneg  = target_r[13];
  assign err_c = {{14{target_r[13]}}, target_r, 4'b0000} - speed_r;

  // integral with anti-windup clamp
  assign isum = 43'(integ_base_r) + mul_prod[42:0];
  always_comb begin
    if (isum > $signed(INTEG_LIM)) begin
      integ_c = 28'(INTEG_LIM);
    end else if (isum < -$signed(INTEG_LIM)) begin
      integ_c = -28'(INTEG_LIM);
    end else begin
      integ_c = isum[27:0];
    end
  end

  // derivative numerator magnitude
  assign ediff = 33'(err_r) - 33'(last_err_r[ch_r]);
  assign emag  = ediff[32] ? 33'(-ediff) : 33'(ediff);
  assign dq    = dneg_r ? -MUL_A_W'(div_quo) : MUL_A_W'(div_quo);

  // output scaling: mag * 65535 >> 20, then divide by 6800
  assign umag   = u_r[U_W-1] ? -u_r : u_r;
  assign scaled = {umag[32:0], 16'b0} - 49'(umag[32:0]);

  // operand selection for the shared units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      ST_ERR: begin
        mul_a = MUL_A_W'(err_c);
        mul_b = MUL_B_W'(per_eff);
      end
      ST_MUL_INT: begin
        div_num = emag;
        div_den = DIV_D_W'(per_eff);
      end
      ST_DIV_DER: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = gain_p_r;
      end
      ST_MUL_P: begin
        mul_a = MUL_A_W'(integ_r);
        mul_b = gain_i_r;
      end
      ST_MUL_I: begin
        mul_a = deriv_r;
        mul_b = gain_d_r;
      end
      ST_SCALE: begin
        div_num = DIV_N_W'(scaled[48:20]);
        div_den = RPM_FULL;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // sequencer next state and unit starts
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        if (mul_st.done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_DER;
        end
      end
      ST_DIV_DER: begin
        if (div_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        if (mul_st.done) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (umag >= SAT_MAG) begin
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_OUT;
        end
      end
      ST_DIV_OUT: begin
        if (div_st.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 14'sd5000;
      gain_p_r <= 24'd65536;
      gain_i_r <= 24'd328;
      gain_d_r <= 24'd136315;
      period_r <= 10'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET: target_r <= cfg_data[13:0];
        REG_GAIN_P: gain_p_r <= cfg_data;
        REG_GAIN_I: gain_i_r <= cfg_data;
        REG_GAIN_D: gain_d_r <= cfg_data;
        REG_PERIOD: period_r <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // per-motor state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        last_count_r[k] <= '0;
        integ_acc_r[k]  <= '0;
        last_err_r[k]   <= '0;
        dir_r[k]        <= 1'b0;
      end
    end else begin
      case (state_r)
        ST_SPEED: last_count_r[ch_r] <= count_r;
        ST_ERR: begin
          if ((tpos && dir_r[ch_r]) || (tneg && !dir_r[ch_r])) begin
            dir_r[ch_r] <= tneg;
          end
        end
        ST_MUL_INT: begin
          if (mul_st.done) begin
            integ_acc_r[ch_r] <= integ_c;
            last_err_r[ch_r]  <= err_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ch_r    <= (NUM_MOTORS > 1) ? CH_W'(in_tuser[0]) : '0;
        count_r <= in_tdata;
      end
      ST_SPEED: speed_r <= speed_c;
      ST_ERR: begin
        err_r <= err_c;
        if ((tpos && dir_r[ch_r]) || (tneg && !dir_r[ch_r])) begin
          integ_base_r <= '0;
        end else begin
          integ_base_r <= integ_acc_r[ch_r];
        end
      end
      ST_MUL_INT: begin
        if (mul_st.done) begin
          integ_r <= integ_c;
          dneg_r  <= ediff[32];
        end
      end
      ST_DIV_DER: begin
        if (div_st.done) begin
          deriv_r <= dq;
          u_r     <= '0;
        end
      end
      ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
        if (mul_st.done) u_r <= u_r + U_W'(mul_prod);
      end
      ST_SCALE: begin
        uneg_r <= u_r[U_W-1];
        q_r    <= PWM_FULL;
        sat_r  <= umag >= SAT_MAG;
      end
      ST_DIV_OUT: begin
        if (div_st.done) begin
          if (div_quo > DIV_N_W'(PWM_FULL)) begin
            q_r   <= PWM_FULL;
            sat_r <= 1'b1;
          end else begin
            q_r <= div_quo[16:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_id_r    <= ch_r[0];
      out_drive_r <= uneg_r ? -q_r : q_r;
      out_sat_r   <= sat_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_drive_r};
  assign out_tuser  = {out_sat_r, out_id_r};

  // a new result only appears when the sequencer hands one over
  `MSPL_ASSERT_NXT(a_out_from_seq, !out_valid_r && state_r != ST_OUT, !out_valid_r)
  // the two serial units never run at the same time
  `MSPL_ASSERT_IMP(a_units_exclusive, mul_st.busy, !div_st.busy)
  // a saturated command always has full magnitude
  `MSPL_ASSERT_IMP(a_sat_full, out_valid_r && out_sat_r,
                   out_drive_r == PWM_FULL || out_drive_r == -PWM_FULL)

endmodule

`default_nettype wire

// File: tb/sv/motor_speed_pid_loop_checker.sv
// drive command predictor and result checker for the motor speed pid loop
// depends on mspl_pkg for register indexes; watches input, result and config channels
`default_nettype none

module motor_speed_pid_loop_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output int               err_count,
  output int               pending
);
  import mspl_pkg::*;

  typedef struct packed {
    logic        motor_id;
    logic [16:0] drive_value;
    logic        drive_saturated;
  } drive_cmd_t;

  drive_cmd_t cmd_q[$];

  // mirrored register and per-motor state
  longint setpoint, kp, ki, kd, per_ms;
  longint prev_count[NUM_MOTORS];
  longint integ[NUM_MOTORS];
  longint prev_err[NUM_MOTORS];
  bit     reverse[NUM_MOTORS];

  assign pending = cmd_q.size();

  function automatic longint clampl(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic predict_drive(input logic ch_sel, input logic signed [31:0] cnt);
    int       ch;
    longint   p, spd, e, ig, dv, mag, q;
    longint   u_hi;
    logic signed [127:0] u;
    bit       neg, sat;
    drive_cmd_t c;
    ch = int'(ch_sel) % NUM_MOTORS;
    p = (per_ms == 0) ? 1 : per_ms;
    spd = clampl((longint'(cnt) - prev_count[ch]) * 75, 64'sd1 <<< 30);
    prev_count[ch] = longint'(cnt);
    // setpoint reversal clears the integral
    if ((setpoint > 0 && reverse[ch]) || (setpoint < 0 && !reverse[ch])) begin
      integ[ch] = 0;
      reverse[ch] = !(setpoint > 0);
    end
    e = setpoint * 16 - spd;
    ig = clampl(integ[ch] + e * p, 64'sd3375468 * 16);
    integ[ch] = ig;
    dv = (e - prev_err[ch]) / p;
    prev_err[ch] = e;
    u = 128'(kp) * 128'(e) + 128'(ki) * 128'(ig) + 128'(kd) * 128'(dv);
    neg = u < 0;
    u = neg ? -u : u;
    sat = 0;
    if (u >= (128'sd7000 <<< 20)) begin
      q = 65535;
      sat = 1;
    end else begin
      u_hi = longint'((u * 65535) / (128'sd6800 <<< 20));
      q = u_hi;
      if (q > 65535) begin
        q = 65535;
        sat = 1;
      end
    end
    mag = neg ? -q : q;
    c.motor_id = ch[0];
    c.drive_value = mag[16:0];
    c.drive_saturated = sat;
    cmd_q.push_back(c);
  endtask

  always @(posedge clk) begin
    drive_cmd_t got, want;
    if (!rst_n) begin
      setpoint = 5000; kp = 65536; ki = 328; kd = 136315; per_ms = 100;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        prev_count[k] = 0; integ[k] = 0; prev_err[k] = 0; reverse[k] = 0;
      end
      cmd_q.delete();
      err_count <= 0;
    end else begin
      // config beat
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TARGET: setpoint = longint'($signed(cfg_data[13:0]));
          REG_GAIN_P: kp = longint'(cfg_data);
          REG_GAIN_I: ki = longint'(cfg_data);
          REG_GAIN_D: kd = longint'(cfg_data);
          REG_PERIOD: per_ms = longint'(cfg_data[9:0]);
          default: ;
        endcase
      end
      // result beat against oldest expectation
      if (out_tvalid && out_tready) begin
        got.motor_id = out_tuser[0];
        got.drive_value = out_tdata[16:0];
        got.drive_saturated = out_tuser[1];
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          err_count <= err_count + 1;
        end else begin
          want = cmd_q.pop_front();
          if (got !== want || out_tdata[23:17] !== 7'd0) begin
            $display("%0t: mismatch expected %p actual %p (pad %h)", $time, want, got,
                     out_tdata[23:17]);
            err_count <= err_count + 1;
          end
        end
      end
      // input beat
      if (in_tvalid && in_tready) predict_drive(in_tuser[0], in_tdata);
    end
  end
endmodule

`default_nettype wire

// File: tb/sv/motor_speed_pid_loop_tb.sv
// testbench top for the motor speed pid loop: clock, reset, encoder beats, config writes
// depends on mspl_pkg, motor_speed_pid_loop and motor_speed_pid_loop_checker
`default_nettype none

module motor_speed_pid_loop_tb;
  import mspl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] encoder_count
  logic [0:0]  in_tuser = '0;   // [0] motor_select
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;       // [16:0] drive_value, [23:17] zero
  logic [1:0]  out_tuser;       // [0] motor_id, [1] drive_saturated
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          err_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  bit          hold_off = 0;

  always #5 clk = ~clk;

  motor_speed_pid_loop u_top (.*);
  motor_speed_pid_loop_checker u_chk (.*);

  // receiver stall process
  always @(posedge clk) begin
    if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // wait for idle block before config writes
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_count(input logic ch, input logic [31:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= cnt;
    in_tuser <= ch;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_input();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // mostly small speed steps around the last count, sometimes any value
  task automatic random_counts(input int n);
    logic [31:0] base[2];
    logic        ch;
    base[0] = $urandom; base[1] = $urandom;
    repeat (n) begin
      ch = $urandom_range(1);
      if ($urandom_range(9) == 0) base[ch] = $urandom;
      else base[ch] = base[ch] + 32'($signed($urandom_range(3000)) - 1500);
      send_count(ch, base[ch]);
    end
    idle_input();
  endtask

  task automatic random_cfg();
    write_reg(REG_TARGET, 24'($urandom_range(13600) - 6800));
    write_reg(REG_GAIN_P, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(200000)));
    write_reg(REG_GAIN_I, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(5000)));
    write_reg(REG_GAIN_D, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(300000)));
    write_reg(REG_PERIOD, 24'($urandom_range(1023)));
  endtask

  initial begin
    #2000000000;
    $display("motor_speed_pid_loop test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, extreme counts, both channels
    send_count(0, 32'h7fffffff);
    send_count(0, 32'h80000000);
    send_count(1, 32'd0);
    send_count(1, 32'd13);
    send_count(0, 32'h80000001);
    send_count(1, 32'hffffffff);
    idle_input();
    drain();
    // unknown register index is ignored
    write_reg(reg_idx_t'(3'd7), 24'hffffff);
    write_reg(REG_TARGET, 24'h002000);  // -8192, beyond range: reverses direction
    write_reg(REG_PERIOD, 24'd0);       // zero period treated as one
    write_reg(REG_GAIN_P, 24'hffffff);
    write_reg(REG_GAIN_I, 24'hffffff);
    write_reg(REG_GAIN_D, 24'hffffff);
    send_count(0, 32'h00000100);
    send_count(1, 32'h7fff0000);
    send_count(0, 32'h00000100);
    idle_input();
    drain();
    write_reg(REG_TARGET, 24'd0);       // zero setpoint leaves direction alone
    write_reg(REG_PERIOD, 24'd1023);
    write_reg(REG_GAIN_P, 24'd0);
    write_reg(REG_GAIN_I, 24'd0);
    write_reg(REG_GAIN_D, 24'd1);
    send_count(0, 32'h00000200);
    send_count(1, 32'h7fff0040);
    idle_input();
    drain();
    write_reg(REG_TARGET, 24'h001fff);  // 8191, flips back to forward
    write_reg(REG_GAIN_P, 24'd65536);
    write_reg(REG_GAIN_I, 24'd328);
    write_reg(REG_PERIOD, 24'd1000);
    send_count(0, 32'h00000300);
    send_count(1, 32'h00000000);
    send_count(0, 32'h55555555);
    send_count(1, 32'haaaaaaaa);
    idle_input();
    drain();

    // long receiver hold-off while samples keep coming
    hold_off = 1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      random_counts(8);
    join
    drain();

    // random phases with varied idling
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      random_cfg();
      random_counts(50);
      drain();
    end

    if (err_count == 0) begin
      $display("motor_speed_pid_loop test passed");
    end else begin
      $display("motor_speed_pid_loop test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
